// ===== sv/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the PPM frame decoder: request and response
// payloads, configuration bundle, request kinds, link states and CSR indexes.
// ----------------------------------------------------------------------------
package pfd_pkg;

   // Storage and limits
   localparam int NUM_CHANNELS  = 8;
   localparam int MAX_OVERFLOWS = 10;
   localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);

   localparam logic [3:0]  GOOD_MIN_CHANNELS = 4'd4;
   localparam logic [3:0]  COUNTER_MAX       = 4'd15;

   // Register reset values
   localparam logic [19:0] SYNC_RESET     = 20'd6000;
   localparam logic [19:0] CENTER_RESET   = 20'd3000;
   localparam logic [14:0] DEADBAND_RESET = 15'd10;
   localparam logic [3:0]  DEFCH_RESET    = 4'd8;

   // Request kinds
   localparam logic [1:0] KIND_CAPTURE  = 2'd0;
   localparam logic [1:0] KIND_OVERFLOW = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   // Link states
   localparam logic [1:0] LINK_LOST = 2'd0;
   localparam logic [1:0] LINK_SYNC = 2'd1;
   localparam logic [1:0] LINK_GOOD = 2'd2;

   // CSR indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_VALUE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_COUNT  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] capture_time;
      logic [2:0]  channel_index;
      logic        keep_new_data;
      logic [1:0]  keep_link_state;
   } req_type;

   typedef struct packed {
      logic signed [15:0] channel_value;
      logic [1:0]         link_state;
      logic               new_frame;
      logic [3:0]         channel_count;
   } rsp_type;

   typedef struct packed {
      logic [19:0] sync_threshold;
      logic [19:0] center_value;
      logic [14:0] deadband;
   } cfg_type;

endpackage

// ===== sv/ppm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// A request passes the input register, then the result register, before its
// response is valid; throughput: one request per cycle while the response is
// not stalled, set by the state update in the engine. A stalled response
// holds the input register and stalls the request channel in the same cycle.
// Reset is synchronous: all state, the width store (loaded with the centre
// reset value) and the valid flags of the registers return at once.
// ----------------------------------------------------------------------------
module ppm_frame_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pfd_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pfd_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic              req_valid_ff;
   pfd_pkg::req_type  req_data_ff;
   logic              rsp_valid_ff;
   pfd_pkg::rsp_type  rsp_data_ff;
   logic              out_open;
   logic              advance;
   pfd_pkg::cfg_type  cfg;
   pfd_pkg::rsp_type  result;

   // Handshake: advance when the result register is free or being drained
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_open;
   assign req_stall = req_valid_ff && !out_open;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pfd_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pfd_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_data_ff),
      .cfg   (cfg),
      .rsp   (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// ===== sv/pfd_regs.sv =====
// ----------------------------------------------------------------------------
// pfd_regs
// Configuration register file: takes CSR writes and presents the settings
// used by the decode engine.
// ----------------------------------------------------------------------------
module pfd_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output pfd_pkg::cfg_type                 cfg
);

   pfd_pkg::cfg_type cfg_ff;
   pfd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pfd_pkg::CSR_SYNC_THRESHOLD: cfg_in.sync_threshold = csr_wdata[19:0];
            pfd_pkg::CSR_CENTER_VALUE:   cfg_in.center_value   = csr_wdata[19:0];
            pfd_pkg::CSR_DEADBAND:       cfg_in.deadband       = csr_wdata[14:0];
            // default count only loads at reset, which restores its reset value
            pfd_pkg::CSR_DEFAULT_COUNT:  cfg_in = cfg_ff;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_threshold <= pfd_pkg::SYNC_RESET;
         cfg_ff.center_value   <= pfd_pkg::CENTER_RESET;
         cfg_ff.deadband       <= pfd_pkg::DEADBAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/pfd_engine.sv =====
// ----------------------------------------------------------------------------
// pfd_engine
// Decoder state and update: pulse length measurement, frame
// sync detection, width store, link tracking and centred channel reads.
// ----------------------------------------------------------------------------
module pfd_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  pfd_pkg::req_type  req,
   input  pfd_pkg::cfg_type  cfg,
   output pfd_pkg::rsp_type  rsp
);

   logic [15:0] last_ff,    last_in;
   logic [3:0]  ovf_ff,     ovf_in;
   logic [3:0]  counter_ff, counter_in;
   logic [3:0]  frame_ff,   frame_in;
   logic [1:0]  link_ff,    link_in;
   logic        flag_ff,    flag_in;
   logic [19:0] widths_ff [pfd_pkg::NUM_CHANNELS];

   logic [3:0]                  ovf_adj;
   logic [15:0]                 delta;
   logic [19:0]                 pulse_len;
   logic [3:0]                  counter_next;
   logic                        width_we;
   logic [pfd_pkg::CH_IDX_W-1:0] width_waddr;
   logic [pfd_pkg::CH_IDX_W-1:0] read_idx;
   logic                        read_in_range;
   logic [19:0]                 read_width;
   logic [15:0]                 centred;
   logic signed [16:0]          centred_s;
   logic signed [16:0]          band_s;
   logic                        in_band;
   logic [15:0]                 value;

   // Pulse length: wrapped delta plus one timer period per overflow
   always_comb begin
      delta   = req.capture_time - last_ff;
      ovf_adj = ovf_ff;
      if (req.capture_time < last_ff && ovf_ff != 4'd0) begin
         ovf_adj = ovf_ff - 4'd1;
      end
      pulse_len    = {ovf_adj, delta};
      counter_next = (counter_ff < pfd_pkg::COUNTER_MAX) ? counter_ff + 4'd1 : counter_ff;
      width_waddr  = counter_ff[pfd_pkg::CH_IDX_W-1:0];
   end

   // Centred, deadbanded read
   always_comb begin
      read_idx      = pfd_pkg::CH_IDX_W'(req.channel_index);
      read_in_range = ({1'b0, req.channel_index} < 4'(pfd_pkg::NUM_CHANNELS));
      read_width    = widths_ff[read_idx];
      centred       = read_width[15:0] - cfg.center_value[15:0];
      centred_s     = $signed({centred[15], centred});
      band_s        = $signed({2'b00, cfg.deadband});
      in_band       = (centred_s < band_s) && (centred_s > -band_s);
      value         = 16'd0;
      if (link_ff != pfd_pkg::LINK_LOST && read_in_range && !in_band) begin
         value = centred;
      end
   end

   // Next state for each request kind
   always_comb begin
      last_in    = last_ff;
      ovf_in     = ovf_ff;
      counter_in = counter_ff;
      frame_in   = frame_ff;
      link_in    = link_ff;
      flag_in    = flag_ff;
      width_we   = 1'b0;
      rsp.channel_value = '0;
      unique case (req.kind)
         pfd_pkg::KIND_CAPTURE: begin
            ovf_in  = 4'd0;
            last_in = req.capture_time;
            if (pulse_len > cfg.sync_threshold) begin
               frame_in   = counter_ff;
               counter_in = 4'd0;
               if (link_ff == pfd_pkg::LINK_LOST) begin
                  link_in = pfd_pkg::LINK_SYNC;
               end
            end else begin
               width_we   = ({1'b0, counter_ff} < 5'(pfd_pkg::NUM_CHANNELS));
               counter_in = counter_next;
               if (counter_next >= pfd_pkg::GOOD_MIN_CHANNELS &&
                   link_ff != pfd_pkg::LINK_LOST) begin
                  link_in = pfd_pkg::LINK_GOOD;
                  if (counter_next == frame_ff) begin
                     flag_in = 1'b1;
                  end
               end
            end
         end
         pfd_pkg::KIND_OVERFLOW: begin
            if (ovf_ff >= 4'(pfd_pkg::MAX_OVERFLOWS)) begin
               ovf_in  = 4'(pfd_pkg::MAX_OVERFLOWS);
               link_in = pfd_pkg::LINK_LOST;
            end else begin
               ovf_in = ovf_ff + 4'd1;
            end
         end
         pfd_pkg::KIND_READ: begin
            rsp.channel_value = $signed(value);
            flag_in = flag_ff & req.keep_new_data;
            link_in = link_ff & req.keep_link_state;
         end
         pfd_pkg::KIND_UNUSED: begin
            link_in = link_ff;
         end
         default: begin
            link_in = link_ff;
         end
      endcase
      rsp.link_state    = link_in;
      rsp.new_frame     = flag_in;
      rsp.channel_count = frame_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         ovf_ff     <= '0;
         counter_ff <= '0;
         frame_ff   <= pfd_pkg::DEFCH_RESET;
         link_ff    <= pfd_pkg::LINK_LOST;
         flag_ff    <= 1'b0;
      end else if (fire) begin
         last_ff    <= last_in;
         ovf_ff     <= ovf_in;
         counter_ff <= counter_in;
         frame_ff   <= frame_in;
         link_ff    <= link_in;
         flag_ff    <= flag_in;
      end
   end

   // Width store, centred at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pfd_pkg::NUM_CHANNELS; i++) begin
            widths_ff[i] <= pfd_pkg::CENTER_RESET;
         end
      end else if (fire && width_we) begin
         widths_ff[width_waddr] <= pulse_len;
      end
   end

endmodule
